@@ hdl/slzm_pkg.sv @@
// Package for the SysEx LED zone mixer: item types, codes and the zone color table.
// No dependencies.
package slzm_pkg;

  localparam int LedCount  = 64;
  localparam int ZoneCount = 16;
  localparam int StoreDepth = 48;
  localparam int LedIdxW = $clog2(LedCount);
  localparam int StoreIdxW = $clog2(StoreDepth);

  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_TIMEOUT = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [7:0] CODE_DISACK = 8'h0e;
  localparam logic [7:0] CODE_ACK    = 8'h0f;
  localparam logic [6:0] CMD_LEDS    = 7'h0c;
  localparam logic [6:0] CMD_PING    = 7'h0f;
  localparam logic [7:0] ARG_BAD_CMD = 8'h0c;
  localparam logic [7:0] ARG_NONE    = 8'h7f;
  localparam logic [7:0] BYTE_EOX    = 8'hf7;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] port;
    logic [7:0] data_byte;
    logic [6:0] led_index;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] reply_byte;
    logic [7:0] reply_port;
    logic       last_of_run;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } out_item_t;

  function automatic logic [7:0] hdr_byte(input logic [2:0] k);
    case (k)
      3'd0:    return 8'hf0;
      3'd3:    return 8'h7e;
      3'd4:    return 8'h50;
      default: return 8'h00;
    endcase
  endfunction

  // Zone color as {red, green, blue}.
  function automatic logic [23:0] zone_rgb(input logic [3:0] z);
    case (z)
      4'd0:    return {8'd40, 8'd0,  8'd0};
      4'd1:    return {8'd0,  8'd40, 8'd0};
      4'd2:    return {8'd0,  8'd0,  8'd40};
      4'd3:    return {8'd40, 8'd40, 8'd0};
      4'd4:    return {8'd0,  8'd40, 8'd40};
      4'd5:    return {8'd40, 8'd0,  8'd40};
      4'd6:    return {8'd60, 8'd0,  8'd0};
      4'd7:    return {8'd20, 8'd40, 8'd0};
      4'd8:    return {8'd20, 8'd0,  8'd40};
      4'd9:    return {8'd60, 8'd40, 8'd0};
      4'd10:   return {8'd20, 8'd40, 8'd40};
      4'd11:   return {8'd60, 8'd0,  8'd40};
      4'd12:   return {8'd40, 8'd20, 8'd0};
      4'd13:   return {8'd0,  8'd60, 8'd0};
      4'd14:   return {8'd0,  8'd20, 8'd40};
      default: return {8'd40, 8'd60, 8'd0};
    endcase
  endfunction

endpackage

@@ hdl/slzm_stream_if.sv @@
// Valid/ready channels carrying one item of type in_item_t or out_item_t.
// Depends on slzm_pkg for the item types.
interface slzm_in_if;
  import slzm_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface slzm_out_if;
  import slzm_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/sysex_led_zone_mixer_top.sv @@
// SysEx LED zone mixer top level: parser, receive buffer, LED store, reply sequencer.
// Depends on slzm_pkg and the slzm stream interfaces.
// Steps: a plain byte or timeout passes through S_DECODE; a read goes on through S_READ and S_READ_OUT.
// A reply is a run of eight output items. The end of an LED command with stored data first
// clears the LED valid bits, then walks each triple and each covered LED on the one
// shared saturating adder before the reply.
// Throughput: one item at a time; input is held off while busy or while a result waits.
// Reset: parser idle, LED store cleared by valid bits, receive buffer undefined.
module sysex_led_zone_mixer_top (
  input  logic clk_i,
  input  logic rst_ni,
  slzm_in_if.sink    in_i,
  slzm_out_if.source out_o
);
  import slzm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_READ, S_READ_OUT, S_CLEAR, S_TRIP, S_TRIP_WAIT, S_TRIP_CHK,
    S_LED_RD, S_LED_WR, S_REPLY
  } state_e;

  state_e state_q;
  in_item_t item_q;
  logic [2:0] hdr_cnt_q;
  logic in_msg_q, have_cmd_q;
  logic [6:0] cmd_q;
  logic [7:0] owner_q;
  logic [5:0] fill_q;
  logic [6:0] store [StoreDepth];
  logic [23:0] leds [LedCount];
  logic [LedCount-1:0] led_vld_q;
  logic [6:0] store_rd_q;
  logic [23:0] led_rd_q;
  logic [5:0] pos_q;
  logic [1:0] sub_q;
  logic [3:0] zone_q;
  logic [6:0] hi_q;
  logic [7:0] led_q;
  logic [7:0] code_q, arg_q;
  logic [2:0] rep_k_q;
  logic out_vld_q;
  out_item_t out_q;
  logic [StoreIdxW-1:0] st_addr;
  logic [LedIdxW-1:0] led_addr;
  logic [23:0] zc, sum;
  logic [8:0] ch0, ch1, ch2;

  assign in_i.ready = (state_q == S_IDLE) && !out_vld_q;
  assign out_o.valid = out_vld_q;
  assign out_o.data = out_q;

  // Store read address (next triple field during the walk), LED read address and saturating sum.
  always_comb begin
    st_addr = StoreIdxW'(pos_q + 6'(sub_q));
    led_addr = (state_q == S_READ) ? LedIdxW'(item_q.led_index) : LedIdxW'(led_q);
    zc = zone_rgb(zone_q);
    ch0 = {1'b0, led_rd_q[23:16]} + {1'b0, zc[23:16]};
    ch1 = {1'b0, led_rd_q[15:8]} + {1'b0, zc[15:8]};
    ch2 = {1'b0, led_rd_q[7:0]} + {1'b0, zc[7:0]};
    sum = {ch0[8] ? 8'hff : ch0[7:0], ch1[8] ? 8'hff : ch1[7:0],
           ch2[8] ? 8'hff : ch2[7:0]};
  end

  always_ff @(posedge clk_i) begin
    store_rd_q <= store[st_addr];
    led_rd_q <= led_vld_q[led_addr] ? leds[led_addr] : '0;
    if (state_q == S_DECODE && item_q.operation == OP_BYTE && in_msg_q && have_cmd_q
        && cmd_q == CMD_LEDS && item_q.data_byte[7] == 1'b0 && fill_q < 6'(StoreDepth)
        && !(owner_q != item_q.port))
      store[StoreIdxW'(fill_q)] <= item_q.data_byte[6:0];
    if (state_q == S_LED_WR) leds[led_addr] <= sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hdr_cnt_q <= '0; in_msg_q <= 1'b0; have_cmd_q <= 1'b0; cmd_q <= '0;
      owner_q <= '0; fill_q <= '0; led_vld_q <= '0;
      out_vld_q <= 1'b0; rep_k_q <= '0;
      pos_q <= '0; sub_q <= '0; zone_q <= '0; hi_q <= '0; led_q <= '0;
      code_q <= '0; arg_q <= '0;
    end else begin
      // The reply state reloads the output register itself.
      if (out_vld_q && out_o.ready && state_q != S_REPLY) out_vld_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid && in_i.ready) begin
            item_q <= in_i.data;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          state_q <= S_IDLE;
          unique case (item_q.operation)
            OP_READ: state_q <= S_READ;
            OP_TIMEOUT: begin
              if (in_msg_q && item_q.port == owner_q) begin
                hdr_cnt_q <= '0; in_msg_q <= 1'b0; have_cmd_q <= 1'b0; cmd_q <= '0;
              end
            end
            OP_BYTE: begin
              if (!(in_msg_q && item_q.port != owner_q)) begin
                owner_q <= item_q.port;
                if (!in_msg_q) begin
                  if (hdr_cnt_q >= 3'd5 || item_q.data_byte != hdr_byte(hdr_cnt_q)) begin
                    hdr_cnt_q <= '0; have_cmd_q <= 1'b0; cmd_q <= '0;
                  end else begin
                    hdr_cnt_q <= hdr_cnt_q + 3'd1;
                    if (hdr_cnt_q == 3'd4) in_msg_q <= 1'b1;
                  end
                end else if (item_q.data_byte[7]) begin
                  hdr_cnt_q <= '0; in_msg_q <= 1'b0; have_cmd_q <= 1'b0; cmd_q <= '0;
                  if (item_q.data_byte == BYTE_EOX && have_cmd_q) begin
                    if (cmd_q == CMD_LEDS) begin
                      code_q <= CODE_ACK; arg_q <= ARG_NONE;
                      pos_q <= '0; sub_q <= '0; led_q <= '0;
                      state_q <= (fill_q != '0) ? S_CLEAR : S_REPLY;
                      rep_k_q <= '0;
                    end else if (cmd_q == CMD_PING) begin
                      code_q <= CODE_ACK; arg_q <= 8'h00; rep_k_q <= '0;
                      state_q <= S_REPLY;
                    end
                  end
                end else if (!have_cmd_q) begin
                  if (item_q.data_byte[6:0] == CMD_LEDS
                      || item_q.data_byte[6:0] == CMD_PING) begin
                    have_cmd_q <= 1'b1;
                    cmd_q <= item_q.data_byte[6:0];
                    if (item_q.data_byte[6:0] == CMD_LEDS) fill_q <= '0;
                  end else begin
                    // Unknown command: answer and drop the message.
                    code_q <= CODE_DISACK; arg_q <= ARG_BAD_CMD; rep_k_q <= '0;
                    hdr_cnt_q <= '0; in_msg_q <= 1'b0;
                    state_q <= S_REPLY;
                  end
                end else if (cmd_q == CMD_LEDS && fill_q < 6'(StoreDepth)) begin
                  fill_q <= fill_q + 6'd1;
                end
              end
            end
            default: ;
          endcase
        end
        S_READ: state_q <= S_READ_OUT;
        S_READ_OUT: begin
          out_q <= '{result_kind: 1'b1, reply_byte: 8'h00, reply_port: 8'h00,
                     last_of_run: 1'b1,
                     red_level: (item_q.led_index < 7'(LedCount)) ? led_rd_q[23:16] : 8'h00,
                     green_level: (item_q.led_index < 7'(LedCount)) ? led_rd_q[15:8] : 8'h00,
                     blue_level: (item_q.led_index < 7'(LedCount)) ? led_rd_q[7:0] : 8'h00};
          out_vld_q <= 1'b1;
          state_q <= S_IDLE;
        end
        S_CLEAR: begin
          // Clear by dropping all valid bits in one step.
          led_vld_q <= '0;
          state_q <= S_TRIP;
        end
        S_TRIP: begin
          // End the walk, flag a short triple, or fetch zone, lower, upper one field per cycle.
          if (pos_q >= fill_q) state_q <= S_REPLY;
          else if (pos_q + 6'd2 >= fill_q) begin
            code_q <= CODE_DISACK;
            if (arg_q == ARG_NONE) arg_q <= {2'b00, pos_q};
            pos_q <= pos_q + 6'd3;
          end else begin
            sub_q <= 2'd1;
            state_q <= S_TRIP_WAIT;
          end
        end
        S_TRIP_WAIT: begin
          unique case (sub_q)
            2'd1: begin
              if (store_rd_q >= 7'(ZoneCount)) begin
                code_q <= CODE_DISACK;
                if (arg_q == ARG_NONE) arg_q <= {2'b00, pos_q};
                pos_q <= pos_q + 6'd3; sub_q <= '0;
                state_q <= S_TRIP;
              end else begin
                zone_q <= store_rd_q[3:0];
                sub_q <= 2'd2;
              end
            end
            2'd2: begin
              led_q <= {1'b0, store_rd_q};
              sub_q <= 2'd3;
            end
            default: begin
              hi_q <= store_rd_q;
              sub_q <= '0;
              state_q <= S_TRIP_CHK;
            end
          endcase
        end
        S_TRIP_CHK: begin
          if (led_q > {1'b0, hi_q} || led_q >= 8'(LedCount)) begin
            pos_q <= pos_q + 6'd3;
            state_q <= S_TRIP;
          end else state_q <= S_LED_RD;
        end
        S_LED_RD: state_q <= S_LED_WR;
        S_LED_WR: begin
          led_vld_q[led_addr] <= 1'b1;
          led_q <= led_q + 8'd1;
          state_q <= S_TRIP_CHK;
        end
        S_REPLY: begin
          if (!out_vld_q || out_o.ready) begin
            out_q.result_kind <= 1'b0;
            out_q.reply_port <= owner_q;
            out_q.last_of_run <= (rep_k_q == 3'd7);
            out_q.red_level <= '0; out_q.green_level <= '0; out_q.blue_level <= '0;
            case (rep_k_q)
              3'd5:    out_q.reply_byte <= code_q;
              3'd6:    out_q.reply_byte <= arg_q;
              3'd7:    out_q.reply_byte <= BYTE_EOX;
              default: out_q.reply_byte <= hdr_byte(rep_k_q);
            endcase
            out_vld_q <= 1'b1;
            rep_k_q <= rep_k_q + 3'd1;
            if (rep_k_q == 3'd7) state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/tb_sysex_led_zone_mixer_top.sv @@
// Testbench for the SysEx LED zone mixer top level: directed and random MIDI traffic,
// a transaction-level model of parser and LED store, and an in-order result checker.
// Depends on slzm_pkg, the slzm stream interfaces and sysex_led_zone_mixer_top.
module tb_sysex_led_zone_mixer_top;
  import slzm_pkg::*;

  localparam int CycleLimit = 1500000;

  logic clk_i;
  logic rst_ni;

  slzm_in_if  in_ch ();
  slzm_out_if out_ch ();

  sysex_led_zone_mixer_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Model state
  logic [2:0]  hdr_cnt;
  logic        msg_open;
  logic        cmd_seen;
  logic [6:0]  cmd_code;
  logic [7:0]  owner;
  int unsigned fill;
  logic [6:0]  rx_buf [StoreDepth];
  logic [23:0] leds [LedCount];

  out_item_t   reply_queue [$];
  int          mismatches;
  int          cycles;
  bit          idle_en;
  bit          sink_hold;
  int          hold_cnt;

  function automatic logic [7:0] sysex_hdr(input int k);
    case (k)
      0:       return 8'hf0;
      3:       return 8'h7e;
      4:       return 8'h50;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [23:0] zone_color(input int z);
    logic [7:0] r, g, b;
    case (z)
      0:  begin r = 40; g = 0;  b = 0;  end
      1:  begin r = 0;  g = 40; b = 0;  end
      2:  begin r = 0;  g = 0;  b = 40; end
      3:  begin r = 40; g = 40; b = 0;  end
      4:  begin r = 0;  g = 40; b = 40; end
      5:  begin r = 40; g = 0;  b = 40; end
      6:  begin r = 60; g = 0;  b = 0;  end
      7:  begin r = 20; g = 40; b = 0;  end
      8:  begin r = 20; g = 0;  b = 40; end
      9:  begin r = 60; g = 40; b = 0;  end
      10: begin r = 20; g = 40; b = 40; end
      11: begin r = 60; g = 0;  b = 40; end
      12: begin r = 40; g = 20; b = 0;  end
      13: begin r = 0;  g = 60; b = 0;  end
      14: begin r = 0;  g = 20; b = 40; end
      default: begin r = 40; g = 60; b = 0; end
    endcase
    return {r, g, b};
  endfunction

  function automatic void close_msg();
    hdr_cnt  = 0;
    msg_open = 1'b0;
    cmd_seen = 1'b0;
    cmd_code = '0;
  endfunction

  function automatic void push_reply(input logic [7:0] code, input logic [7:0] arg);
    out_item_t o;
    for (int k = 0; k < 8; k++) begin
      o = '0;
      o.reply_byte  = (k < 5) ? sysex_hdr(k) : (k == 5) ? code : (k == 6) ? arg : BYTE_EOX;
      o.reply_port  = owner;
      o.last_of_run = (k == 7);
      reply_queue.push_back(o);
    end
  endfunction

  function automatic void apply_zones();
    logic [7:0]  code, arg;
    int          zn, lo, hi, s;
    logic [23:0] v, zc;
    logic [8:0]  ch;
    code = CODE_ACK;
    arg  = ARG_NONE;
    if (fill != 0) begin
      for (int i = 0; i < LedCount; i++) leds[i] = '0;
      for (int p = 0; p < fill; p += 3) begin
        if (p + 2 >= fill) begin
          code = CODE_DISACK;
          if (arg == ARG_NONE) arg = 8'(p);
          continue;
        end
        zn = rx_buf[p];
        lo = rx_buf[p+1];
        hi = rx_buf[p+2];
        if (zn >= ZoneCount) begin
          code = CODE_DISACK;
          if (arg == ARG_NONE) arg = 8'(p);
          continue;
        end
        zc = zone_color(zn);
        for (int l = lo; l <= hi && l < LedCount; l++) begin
          v = leds[l];
          for (int c = 0; c < 3; c++) begin
            s = 16 - 8 * c;
            ch = v[s +: 8] + zc[s +: 8];
            v[s +: 8] = ch[8] ? 8'hff : ch[7:0];
          end
          leds[l] = v;
        end
      end
    end
    push_reply(code, arg);
  endfunction

  function automatic void predict(input in_item_t it);
    out_item_t o;
    if (it.operation == OP_READ) begin
      o = '0;
      o.result_kind = 1'b1;
      o.last_of_run = 1'b1;
      if (it.led_index < LedCount)
        {o.red_level, o.green_level, o.blue_level} = leds[it.led_index];
      reply_queue.push_back(o);
      return;
    end
    if (it.operation == OP_TIMEOUT) begin
      if (msg_open && it.port == owner) close_msg();
      return;
    end
    if (it.operation != OP_BYTE) return;
    if (msg_open && it.port != owner) return;
    owner = it.port;
    if (!msg_open) begin
      if (hdr_cnt >= 5 || it.data_byte != sysex_hdr(hdr_cnt)) close_msg();
      else begin
        hdr_cnt++;
        if (hdr_cnt == 5) msg_open = 1'b1;
      end
      return;
    end
    if (it.data_byte[7]) begin
      if (it.data_byte == BYTE_EOX && cmd_seen) begin
        if (cmd_code == CMD_LEDS) apply_zones();
        else if (cmd_code == CMD_PING) push_reply(CODE_ACK, 8'h00);
      end
      close_msg();
      return;
    end
    if (!cmd_seen) begin
      cmd_seen = 1'b1;
      cmd_code = it.data_byte[6:0];
      if (cmd_code == CMD_LEDS) fill = 0;
      else if (cmd_code != CMD_PING) begin
        push_reply(CODE_DISACK, ARG_BAD_CMD);
        close_msg();
      end
      return;
    end
    if (cmd_code == CMD_LEDS && fill < StoreDepth) begin
      rx_buf[fill] = it.data_byte[6:0];
      fill++;
    end
  endfunction

  // Drive one item, hold until accepted, then update the model.
  // Valid stays high after acceptance; a gap in the next call or wait_drained drops it.
  task automatic send_item(input logic [1:0] op, input logic [7:0] port,
                           input logic [7:0] b, input logic [6:0] idx);
    in_item_t it;
    int gap;
    it = '{operation: op, port: port, data_byte: b, led_index: idx};
    gap = 0;
    while (idle_en && $urandom_range(99) < 20) gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict(it);
  endtask

  task automatic send_byte(input logic [7:0] port, input logic [7:0] b);
    send_item(OP_BYTE, port, b, 7'($urandom));
  endtask

  task automatic send_header(input logic [7:0] port);
    for (int k = 0; k < 5; k++) send_byte(port, sysex_hdr(k));
  endtask

  task automatic read_led(input logic [6:0] idx);
    send_item(OP_READ, 8'($urandom), 8'($urandom), idx);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (reply_queue.size() != 0) @(posedge clk_i);
    repeat (2400) @(posedge clk_i);
  endtask

  task automatic test_ping_and_bad_cmd();
    send_header(8'hff);
    send_byte(8'hff, 8'h0f);
    send_byte(8'hff, BYTE_EOX);
    send_header(8'h00);
    send_byte(8'h00, 8'h7f);
    send_byte(8'h00, BYTE_EOX);
    send_item(2'd3, 8'h12, 8'hf0, 7'h7f);
  endtask

  task automatic test_led_cmd_edges();
    // full-range zone 15 five times to saturate, then a bad zone and a short triple
    send_header(8'h5a);
    send_byte(8'h5a, 8'h0c);
    send_byte(8'h33, 8'h01);
    for (int r = 0; r < 5; r++) begin
      send_byte(8'h5a, 8'h0f);
      send_byte(8'h5a, 8'h00);
      send_byte(8'h5a, 8'h7f);
    end
    send_byte(8'h5a, 8'h10);
    send_byte(8'h5a, 8'h00);
    send_byte(8'h5a, 8'h05);
    send_byte(8'h5a, 8'h03);
    send_byte(8'h5a, BYTE_EOX);
    read_led(7'd0);
    read_led(7'd63);
    read_led(7'd64);
    read_led(7'h7f);
    send_header(8'h01);
    send_byte(8'h01, 8'h0c);
    send_byte(8'h01, BYTE_EOX);
    send_header(8'h02);
    send_byte(8'h02, 8'h0c);
    send_byte(8'h02, 8'h02);
    send_item(OP_TIMEOUT, 8'h02, 8'h00, 7'h00);
    send_byte(8'h02, BYTE_EOX);
    send_byte(8'h03, 8'hf0);
    send_item(OP_TIMEOUT, 8'h03, 8'h00, 7'h00);
    send_byte(8'h03, 8'h80);
  endtask

  task automatic test_overflow();
    send_header(8'h44);
    send_byte(8'h44, 8'h0c);
    for (int i = 0; i < 52; i++)
      send_byte(8'h44, (i % 3 == 0) ? 8'($urandom_range(15)) : 8'($urandom));
    send_byte(8'h44, BYTE_EOX);
  endtask

  task automatic random_message();
    logic [7:0] port;
    int n, kind;
    port = 8'($urandom_range(3));
    kind = $urandom_range(99);
    if (kind < 10) begin
      send_item(2'($urandom_range(3)), 8'($urandom), 8'($urandom), 7'($urandom));
      return;
    end
    if (kind < 15) send_byte(port, 8'($urandom));
    send_header(port);
    if (kind < 25) begin
      send_byte(port, $urandom_range(1) ? 8'h0f : 8'($urandom));
      send_byte(port, BYTE_EOX);
      return;
    end
    send_byte(port, 8'h0c);
    n = $urandom_range(4);
    for (int t = 0; t < n; t++) begin
      if ($urandom_range(9) == 0) send_byte(port ^ 8'h01, 8'($urandom));
      send_byte(port, ($urandom_range(9) == 0) ? 8'($urandom_range(16, 127))
                                               : 8'($urandom_range(15)));
      send_byte(port, 8'($urandom_range(70)));
      send_byte(port, 8'($urandom_range(70)));
    end
    if ($urandom_range(9) == 0) send_byte(port, 8'($urandom_range(15)));
    if ($urandom_range(19) == 0) send_item(OP_TIMEOUT, port, 8'h00, 7'h00);
    send_byte(port, ($urandom_range(9) == 0) ? 8'($urandom_range(128, 255)) : BYTE_EOX);
    read_led(7'($urandom_range(63)));
  endtask

  task automatic test_random();
    for (int m = 0; m < 8; m++) random_message();
    idle_en = 1'b0;
    for (int m = 0; m < 4; m++) random_message();
    idle_en = 1'b1;
    sink_hold = 1'b1;
    for (int m = 0; m < 4; m++) random_message();
    wait_drained();
  endtask

  // Sink: random stalls, with a long hold-off once requested.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= 0;
    end else if (sink_hold && hold_cnt < 600) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_ch.ready <= !idle_en || $urandom_range(99) >= 20;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (reply_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_ch.data);
      end else if (out_ch.data !== reply_queue[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %p actual %p", reply_queue[0], out_ch.data);
        void'(reply_queue.pop_front());
      end else begin
        void'(reply_queue.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[sysex_led_zone_mixer_top] ERROR");
      $finish;
    end
  end

  initial begin
    hdr_cnt = 0; msg_open = 0; cmd_seen = 0; cmd_code = 0; owner = 0; fill = 0;
    for (int i = 0; i < LedCount; i++) leds[i] = '0;
    mismatches = 0;
    cycles = 0;
    idle_en = 1'b1;
    sink_hold = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_ping_and_bad_cmd();
    test_led_cmd_edges();
    test_overflow();
    wait_drained();
    test_random();
    if (mismatches == 0 && reply_queue.size() == 0) begin
      $display("[sysex_led_zone_mixer_top] OK");
    end else begin
      $display("[sysex_led_zone_mixer_top] ERROR");
    end
    $finish;
  end

endmodule
